[src/flha_pkg.sv]
package flha_pkg;
	localparam int HEAP_UNITS_DEF = 4096;
	localparam int UNIT_BYTES_DEF = 16;
	localparam logic [12:0] GROW_RESET = 13'd1024;

	typedef enum logic [1:0] {
		REQ_MALLOC = 2'd0,
		REQ_CALLOC = 2'd1,
		REQ_FREE   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL,
		ST_SIZE,
		ST_A_RD_ROVER,
		ST_A_RD_P,
		ST_A_CHECK,
		ST_A_SPLIT_WR,
		ST_A_DONE,
		ST_G_CHECK,
		ST_G_WR,
		ST_R_RD_P,
		ST_R_CHECK,
		ST_R_RD_BP,
		ST_R_RD_NX,
		ST_R_MERGE_HI,
		ST_R_RD_PP,
		ST_R_MERGE_LO,
		ST_R_DONE,
		ST_RESULT
	} state_t;
endpackage

[src/flha_hdr_ram.sv]
module flha_hdr_ram #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wlink,
	input  logic [AW:0]   wunits,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rlink,
	output logic [AW:0]   runits
);
	logic [2*AW:0] mem [2**AW];
	logic [2*AW:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wunits, wlink};
		end
		rd_q <= mem[raddr];
	end

	assign rlink  = rd_q[AW-1:0];
	assign runits = rd_q[2*AW:AW];
endmodule

[src/free_list_heap_allocator.sv]
// Next-fit free-list allocator over a heap of header units kept in one RAM with a single
// registered read port. After acceptance a malloc sizes the request (a calloc first forms
// the byte count in the multiplier), reads the rover's link and then walks the free list
// header by header; a block that fits exactly is unlinked, a larger one is split. Growing
// the heap checks the break and writes the new block's header, walks to the insertion
// point, merges and restarts the search. A free walks from the rover to the insertion
// point and merges the block with any neighbour it adjoins. The result cycle follows in
// every case. busy is high from acceptance up to and including the result cycle, and each
// result word is on done for one cycle only, since the receiver cannot stall it.
module free_list_heap_allocator
	import flha_pkg::*;
#(
	parameter int HEAP_UNITS = HEAP_UNITS_DEF,
	parameter int UNIT_BYTES = UNIT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] byte_count,
	input  logic [15:0] elem_size,
	input  logic [11:0] block_addr,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	output logic        done,
	output logic [11:0] alloc_addr,
	output logic        failed
);
	localparam int AW = $clog2(HEAP_UNITS);
	localparam int UW = AW + 1;
	localparam int SH = $clog2(UNIT_BYTES);
	localparam int WW = AW + 3;
	localparam logic [31:0] MAXNEED = 32'(HEAP_UNITS - 1);
	localparam logic [31:0] FREELIM = 32'(HEAP_UNITS);
	localparam logic [31:0] ALLOCLIM = 32'(4 * HEAP_UNITS);

	state_t state_q, state_d;

	logic [12:0]   grow_q;
	logic [AW-1:0] rover_q, brk_q;
	logic          brk_full_q;
	logic          ready_q;
	logic [1:0]    kind_q;
	logic [15:0]   cnt_q, esz_q;
	logic [AW-1:0] baddr_q;
	logic [31:0]   bytes_q;
	logic [UW-1:0] need_q;
	logic [AW-1:0] prevp_q, p_q, nx_q, bp_q;
	logic [UW-1:0] pu_q, bpu_q;
	logic [AW-1:0] bpl_q;
	logic [WW-1:0] steps_q;
	logic [WW-1:0] rsteps_q;
	logic          split_q;
	logic          growing_q;
	logic [AW-1:0] res_addr_q;
	logic          res_fail_q;
	logic [1:0]    ph_q;

	logic          we;
	logic [AW-1:0] waddr, wlink, raddr, rlink;
	logic [UW-1:0] wunits, runits;

	function automatic logic kind_ok(input logic [1:0] k);
		return k != REQ_NONE;
	endfunction

	flha_hdr_ram #(.AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wlink(wlink), .wunits(wunits),
		.raddr(raddr), .rlink(rlink), .runits(runits)
	);

	// The shared adder: one sum of two unit-sized operands per cycle.
	logic [UW:0] add_a, add_b, add_y;
	assign add_y = add_a + add_b;

	logic [UW:0]   grow_n;
	logic [UW+1:0] brk_sum;
	logic [32:0]   round_sum;
	always_comb begin
		logic [UW:0] gc;
		gc = (grow_q == 13'd0) ? (UW+1)'(1) : (UW+1)'(grow_q);
		grow_n = ({1'b0, need_q} < gc) ? gc : {1'b0, need_q};
		brk_sum = {brk_full_q, 1'b0, brk_q} + {1'b0, grow_n};
		round_sum = {1'b0, bytes_q} + 33'(UNIT_BYTES - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grow_q <= GROW_RESET;
			rover_q <= '0;
			brk_q <= AW'(1);
			brk_full_q <= 1'b0;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				grow_q <= cfg_wdata;
			end
			if (state_q == ST_IDLE && start && kind_ok(req_type)) begin
				if (!ready_q) begin
					rover_q <= '0;
				end
				ready_q <= 1'b1;
			end
			if (state_q == ST_G_WR) begin
				{brk_full_q, brk_q} <= (AW+1)'(brk_sum);
			end
			if (state_q == ST_A_DONE && ph_q == 2'd0) begin
				rover_q <= prevp_q;
			end
			if (state_q == ST_R_DONE) begin
				rover_q <= p_q;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_A_DONE) begin
			ph_q <= ph_q + 2'd1;
		end else begin
			ph_q <= '0;
		end
		case (state_q)
			ST_IDLE: begin
				kind_q <= req_type;
				cnt_q <= byte_count;
				esz_q <= elem_size;
				baddr_q <= block_addr[AW-1:0];
				bytes_q <= {16'd0, byte_count};
				res_addr_q <= '0;
				res_fail_q <= 1'b0;
				growing_q <= 1'b0;
			end
			ST_MUL: bytes_q <= cnt_q * esz_q;
			ST_SIZE: begin
				if ((round_sum[32:SH] + 33'd1) > {1'b0, MAXNEED}) begin
					res_fail_q <= 1'b1;
				end
				need_q <= UW'(round_sum[32:SH] + 33'd1);
				prevp_q <= rover_q;
				steps_q <= '0;
			end
			ST_A_RD_P: begin
				p_q <= rlink;
			end
			ST_A_CHECK: begin
				nx_q <= rlink;
				split_q <= runits > need_q;
				if (runits > need_q) begin
					pu_q <= UW'(add_y);
				end else begin
					pu_q <= runits;
				end
				if ({{(32-WW){1'b0}}, steps_q} >= ALLOCLIM) begin
					res_fail_q <= 1'b1;
				end
				if (!(runits >= need_q) && p_q == rover_q) begin
					growing_q <= 1'b1;
				end else if (!(runits >= need_q)) begin
					prevp_q <= p_q;
					p_q <= rlink;
					steps_q <= steps_q + 1'b1;
				end
				if (runits >= need_q) begin
					res_addr_q <= p_q + AW'(1);
				end
			end
			ST_A_SPLIT_WR: begin
				p_q <= AW'(add_y);
				res_addr_q <= AW'(add_y) + AW'(1);
			end
			ST_G_CHECK: begin
				if (brk_sum > (UW+2)'(HEAP_UNITS)) begin
					res_fail_q <= 1'b1;
				end
				bp_q <= brk_q;
				bpu_q <= UW'(grow_n);
			end
			ST_G_WR: begin
				p_q <= rover_q;
				rsteps_q <= '0;
			end
			ST_R_RD_P: begin
				if (!growing_q && kind_q == REQ_FREE) begin
					bp_q <= baddr_q - AW'(1);
					p_q <= rover_q;
					rsteps_q <= '0;
				end
			end
			ST_R_CHECK: begin
				nx_q <= rlink;
				if (!((bp_q > p_q && bp_q < rlink) ||
				      (p_q >= rlink && (bp_q > p_q || bp_q < rlink)))) begin
					// A walk that runs too long leaves the rover where it was.
					if ({{(32-WW){1'b0}}, rsteps_q} >= FREELIM) begin
						p_q <= rover_q;
					end else begin
						p_q <= rlink;
						rsteps_q <= rsteps_q + 1'b1;
					end
				end
			end
			ST_R_RD_BP: begin
				bpu_q <= runits;
				bpl_q <= rlink;
			end
			ST_R_RD_NX: begin
				if (add_y == (UW+1)'(nx_q)) begin
					bpu_q <= UW'(bpu_q + runits);
					bpl_q <= rlink;
				end else begin
					bpl_q <= nx_q;
				end
			end
			ST_R_RD_PP: pu_q <= runits;
			ST_R_DONE: begin
				if (growing_q) begin
					growing_q <= 1'b0;
					prevp_q <= p_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	logic rel_stop, mergelo;
	assign rel_stop = (bp_q > p_q && bp_q < rlink) ||
		(p_q >= rlink && (bp_q > p_q || bp_q < rlink));
	assign mergelo = ((UW+1)'(p_q) + (UW+1)'(pu_q)) == (UW+1)'(bp_q);

	// Adder operand selection and RAM port control.
	always_comb begin
		add_a = '0;
		add_b = '0;
		we = 1'b0;
		waddr = p_q;
		wlink = rlink;
		wunits = runits;
		raddr = p_q;
		case (state_q)
			ST_IDLE: begin
				// The first request of a known kind sets up the empty anchor block at unit zero.
				we = start && !ready_q && kind_ok(req_type);
				waddr = '0;
				wlink = '0;
				wunits = '0;
			end
			ST_A_RD_ROVER: raddr = prevp_q;
			ST_A_RD_P: raddr = rlink;
			ST_A_CHECK: begin
				add_a = {1'b0, runits};
				add_b = {1'b0, ~need_q} + (UW+1)'(1);
				raddr = rlink;
			end
			ST_A_SPLIT_WR: begin
				add_a = (UW+1)'(p_q);
				add_b = {1'b0, pu_q};
				we = 1'b1;
				waddr = p_q;
				wlink = nx_q;
				wunits = pu_q;
			end
			ST_A_DONE: begin
				we = 1'b1;
				if (!split_q) begin
					waddr = prevp_q;
					raddr = prevp_q;
					wlink = nx_q;
					wunits = runits;
					we = (ph_q == 2'd1);
				end else begin
					waddr = p_q;
					raddr = p_q;
					wlink = rlink;
					wunits = need_q;
					we = (ph_q == 2'd1);
				end
			end
			ST_G_WR: begin
				we = 1'b1;
				waddr = bp_q;
				wlink = '0;
				wunits = bpu_q;
			end
			ST_R_RD_P: raddr = growing_q ? rover_q :
				(kind_q == REQ_FREE ? rover_q : p_q);
			ST_R_CHECK: raddr = rel_stop ? bp_q : rlink;
			ST_R_RD_BP: raddr = nx_q;
			ST_R_RD_NX: begin
				add_a = (UW+1)'(bp_q);
				add_b = {1'b0, bpu_q};
				raddr = nx_q;
			end
			ST_R_MERGE_HI: begin
				we = 1'b1;
				waddr = bp_q;
				wlink = bpl_q;
				wunits = bpu_q;
				raddr = p_q;
			end
			ST_R_RD_PP: raddr = p_q;
			ST_R_MERGE_LO: begin
				we = 1'b1;
				waddr = p_q;
				if (mergelo) begin
					wlink = bpl_q;
					wunits = UW'(pu_q + bpu_q);
				end else begin
					wlink = bp_q;
					wunits = pu_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req_type)
						REQ_MALLOC: state_d = ST_SIZE;
						REQ_CALLOC: state_d = ST_MUL;
						REQ_FREE: state_d = (block_addr[AW-1:0] != '0 &&
							({brk_full_q, brk_q} > (AW+1)'(block_addr[AW-1:0]) ||
							brk_full_q)) ? ST_R_RD_P : ST_RESULT;
						default: state_d = ST_RESULT;
					endcase
				end
			end
			ST_MUL: state_d = ST_SIZE;
			ST_SIZE: state_d = ((round_sum[32:SH] + 33'd1) > {1'b0, MAXNEED}) ?
				ST_RESULT : ST_A_RD_ROVER;
			ST_A_RD_ROVER: state_d = ST_A_RD_P;
			ST_A_RD_P: state_d = ST_A_CHECK;
			ST_A_CHECK: begin
				if ({{(32-WW){1'b0}}, steps_q} >= ALLOCLIM) begin
					state_d = ST_RESULT;
				end else if (runits >= need_q) begin
					state_d = (runits == need_q) ? ST_A_DONE : ST_A_SPLIT_WR;
				end else if (p_q == rover_q) begin
					state_d = ST_G_CHECK;
				end else begin
					state_d = ST_A_CHECK;
				end
			end
			ST_A_SPLIT_WR: state_d = ST_A_DONE;
			ST_A_DONE: state_d = (ph_q == 2'd1) ? ST_RESULT : ST_A_DONE;
			ST_G_CHECK: state_d = (brk_sum > (UW+2)'(HEAP_UNITS)) ?
				ST_RESULT : ST_G_WR;
			ST_G_WR: state_d = ST_R_RD_P;
			ST_R_RD_P: state_d = ST_R_CHECK;
			ST_R_CHECK: begin
				if (rel_stop) begin
					state_d = ST_R_RD_BP;
				end else if ({{(32-WW){1'b0}}, rsteps_q} >= FREELIM) begin
					state_d = growing_q ? ST_R_DONE : ST_RESULT;
				end
			end
			ST_R_RD_BP: state_d = ST_R_RD_NX;
			ST_R_RD_NX: state_d = ST_R_MERGE_HI;
			ST_R_MERGE_HI: state_d = ST_R_RD_PP;
			ST_R_RD_PP: state_d = ST_R_MERGE_LO;
			ST_R_MERGE_LO: state_d = ST_R_DONE;
			ST_R_DONE: state_d = growing_q ? ST_A_RD_ROVER : ST_RESULT;
			ST_RESULT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != ST_IDLE;
		done = state_q == ST_RESULT;
		alloc_addr = res_fail_q ? 12'd0 : 12'(res_addr_q);
		failed = res_fail_q;
	end
endmodule

[src/flha_checker.sv]
module flha_props (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [11:0] alloc_addr,
	input logic        failed
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result word outside a busy period");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && failed) |-> alloc_addr == 12'd0) else $error("failed word has address");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not raise busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result word repeated");
endmodule

bind free_list_heap_allocator flha_props u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.alloc_addr(alloc_addr), .failed(failed)
);

[verif/flha_checker.sv]
module flha_checker
	import flha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] byte_count,
	input  logic [15:0] elem_size,
	input  logic [11:0] block_addr,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	input  logic        done,
	input  logic [11:0] alloc_addr,
	input  logic        failed,
	output int          mismatches,
	output int          pending
);
	localparam int unsigned HEAP = HEAP_UNITS_DEF;
	localparam int unsigned UB = UNIT_BYTES_DEF;

	typedef struct {
		logic [11:0] addr;
		logic        fail;
	} grant_t;

	int unsigned hdr_link [HEAP];
	int unsigned hdr_units [HEAP];
	int unsigned rover;
	int unsigned brk;
	bit          list_up;
	int unsigned chunk;
	grant_t      grants_due [$];

	assign pending = grants_due.size();

	// Links the block at header bp into the address-ordered list and merges it with
	// each neighbouring block that it adjoins.
	function automatic void link_free_block(int unsigned bp);
		int unsigned p, nx, steps;
		p = rover;
		steps = 0;
		forever begin
			nx = hdr_link[p] % HEAP;
			if (bp > p && bp < nx)
				break;
			if (p >= nx && (bp > p || bp < nx))
				break;
			steps++;
			if (steps > HEAP)
				return;
			p = nx;
		end
		nx = hdr_link[p] % HEAP;
		if (bp + hdr_units[bp] == nx) begin
			hdr_units[bp] += hdr_units[nx];
			hdr_link[bp] = hdr_link[nx] % HEAP;
		end else begin
			hdr_link[bp] = nx;
		end
		if (p + hdr_units[p] == bp) begin
			hdr_units[p] += hdr_units[bp];
			hdr_link[p] = hdr_link[bp] % HEAP;
		end else begin
			hdr_link[p] = bp;
		end
		rover = p;
	endfunction

	function automatic bit extend_heap(int unsigned need);
		int unsigned nu, c, up;
		c = (chunk == 0) ? 1 : chunk;
		nu = (need < c) ? c : need;
		if (brk + nu > HEAP)
			return 0;
		up = brk;
		hdr_units[up] = nu;
		hdr_link[up] = 0;
		brk += nu;
		link_free_block(up);
		return 1;
	endfunction

	function automatic bit carve_block(longint unsigned bytes, output int unsigned addr);
		longint unsigned need;
		int unsigned n, prevp, p;
		addr = 0;
		need = (bytes + UB - 1) / UB + 1;
		if (need > HEAP - 1)
			return 0;
		n = need;
		prevp = rover;
		p = hdr_link[prevp] % HEAP;
		for (int unsigned steps = 0; steps < 4 * HEAP; steps++) begin
			if (hdr_units[p] >= n) begin
				if (hdr_units[p] == n) begin
					hdr_link[prevp] = hdr_link[p] % HEAP;
				end else begin
					hdr_units[p] -= n;
					p = (p + hdr_units[p]) % HEAP;
					hdr_units[p] = n;
				end
				rover = prevp;
				addr = p + 1;
				return 1;
			end
			if (p == rover) begin
				if (!extend_heap(n))
					return 0;
				p = rover;
			end
			prevp = p;
			p = hdr_link[p] % HEAP;
		end
		return 0;
	endfunction

	function automatic grant_t serve_request(req_t kind, logic [15:0] cnt, logic [15:0] esz,
			logic [11:0] baddr);
		grant_t g;
		int unsigned a;
		longint unsigned bytes;
		g.addr = '0;
		g.fail = 1'b0;
		if (kind != REQ_NONE && !list_up) begin
			hdr_link[0] = 0;
			hdr_units[0] = 0;
			rover = 0;
			list_up = 1;
		end
		if (kind == REQ_MALLOC || kind == REQ_CALLOC) begin
			bytes = (kind == REQ_MALLOC) ? longint'(cnt) : longint'(cnt) * longint'(esz);
			if (carve_block(bytes, a))
				g.addr = a[11:0];
			else
				g.fail = 1'b1;
		end else if (kind == REQ_FREE) begin
			if (baddr != 0 && baddr < brk)
				link_free_block(baddr - 1);
		end
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t g;
		if (!arst_n) begin
			for (int i = 0; i < HEAP; i++) begin
				hdr_link[i] = 0;
				hdr_units[i] = 0;
			end
			rover = 0;
			brk = 1;
			list_up = 0;
			chunk = GROW_RESET;
			mismatches = 0;
			grants_due.delete();
		end else begin
			if (done) begin
				if (grants_due.size() == 0) begin
					$display("%0t: unexpected word: alloc_addr %0d failed %0b", $time,
						alloc_addr, failed);
					mismatches++;
				end else begin
					g = grants_due.pop_front();
					if (alloc_addr !== g.addr) begin
						$display("%0t: alloc_addr expected %0d actual %0d", $time, g.addr,
							alloc_addr);
						mismatches++;
					end
					if (failed !== g.fail) begin
						$display("%0t: failed expected %0b actual %0b", $time, g.fail, failed);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				chunk = cfg_wdata;
			if (start && !busy)
				grants_due.push_back(serve_request(req_t'(req_type), byte_count, elem_size,
					block_addr));
		end
	end
endmodule

[verif/tb_free_list_heap_allocator.sv]
module tb_free_list_heap_allocator;
	import flha_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [1:0]  req_type = REQ_NONE;
	logic [15:0] byte_count = '0;
	logic [15:0] elem_size = '0;
	logic [11:0] block_addr = '0;
	logic        cfg_we = 0;
	logic [12:0] cfg_wdata = '0;
	logic        done;
	logic [11:0] alloc_addr;
	logic        failed;
	int          mismatches;
	int          pending;

	req_t        in_flight [$];
	logic [11:0] live_blocks [$];
	bit          no_gaps;
	int          n_items;
	int          n_fails;

	always #5 clk = ~clk;

	free_list_heap_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req_type(req_type),
		.byte_count(byte_count), .elem_size(elem_size), .block_addr(block_addr),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .alloc_addr(alloc_addr),
		.failed(failed)
	);

	flha_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req_type(req_type),
		.byte_count(byte_count), .elem_size(elem_size), .block_addr(block_addr),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .alloc_addr(alloc_addr),
		.failed(failed), .mismatches(mismatches), .pending(pending)
	);

	// Granted blocks are remembered so that free_one only ever names live blocks.
	always @(posedge clk) begin
		req_t k;
		if (done && in_flight.size() > 0) begin
			k = in_flight.pop_front();
			if ((k == REQ_MALLOC || k == REQ_CALLOC) && !failed)
				live_blocks.push_back(alloc_addr);
			if (failed)
				n_fails++;
		end
		if (start && !busy)
			in_flight.push_back(req_t'(req_type));
	end

	task automatic issue(req_t rt, logic [15:0] bc, logic [15:0] es, logic [11:0] ba);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
		start = 1;
		req_type = rt;
		byte_count = bc;
		elem_size = es;
		block_addr = ba;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		n_items++;
	endtask

	task automatic free_one();
		int idx;
		logic [11:0] a;
		idx = $urandom_range(0, live_blocks.size() - 1);
		a = live_blocks[idx];
		live_blocks.delete(idx);
		issue(REQ_FREE, 16'($urandom), 16'($urandom), a);
	endtask

	task automatic drain();
		start = 0;
		while (in_flight.size() > 0 || pending > 0)
			@(negedge clk);
	endtask

	task automatic set_chunk(logic [12:0] v);
		drain();
		cfg_we = 1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic random_phase(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 42 && live_blocks.size() > 0)
				free_one();
			else if (r < 70)
				issue(REQ_MALLOC, 16'($urandom_range(0, 400)), 16'($urandom), 12'($urandom));
			else if (r < 85)
				issue(REQ_CALLOC, 16'($urandom_range(0, 20)), 16'($urandom_range(0, 64)),
					12'($urandom));
			else if (r < 91)
				issue(REQ_MALLOC, 16'($urandom), 16'($urandom), 12'($urandom));
			else if (r < 95)
				issue(REQ_CALLOC, 16'($urandom), 16'($urandom), 12'($urandom));
			else if (r < 97)
				issue(REQ_FREE, 16'($urandom), 16'($urandom), '0);
			else
				issue(REQ_NONE, 16'($urandom), 16'($urandom), 12'($urandom));
		end
	endtask

	initial begin
		no_gaps = 0;
		n_items = 0;
		n_fails = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Frees before any growth name address zero or lie at or beyond the break point and are dropped.
		issue(REQ_FREE, '0, '0, 12'd4095);
		issue(REQ_FREE, '0, '0, 12'd1);
		issue(REQ_FREE, '0, '0, 12'd0);
		issue(REQ_NONE, 16'hFFFF, 16'hFFFF, 12'hFFF);
		issue(REQ_MALLOC, 16'd0, '0, '0);
		issue(REQ_MALLOC, 16'd1, 16'hFFFF, '0);
		issue(REQ_MALLOC, 16'd16, '0, '0);
		issue(REQ_MALLOC, 16'd17, '0, '0);
		issue(REQ_MALLOC, 16'hFFFF, '0, '0);
		issue(REQ_CALLOC, 16'd0, 16'd0, '0);
		issue(REQ_CALLOC, 16'hFFFF, 16'hFFFF, '0);
		issue(REQ_CALLOC, 16'd3, 16'd5, '0);
		issue(REQ_CALLOC, 16'd1, 16'd65520, '0);
		issue(REQ_MALLOC, 16'd65504, '0, '0);
		issue(REQ_MALLOC, 16'd16000, '0, '0);
		drain();
		while (live_blocks.size() > 0)
			free_one();

		set_chunk(13'd1);
		random_phase(120);
		set_chunk(13'd4096);
		random_phase(90);
		set_chunk(13'd0);
		random_phase(90);
		set_chunk(13'($urandom_range(1, 4096)));
		random_phase(110);
		set_chunk(13'd100);
		random_phase(110);
		set_chunk(13'd1024);
		random_phase(110);

		drain();
		repeat (20) @(negedge clk);
		$display("Ran %0d requests (%0d failed allocations) over six growth chunk settings,",
			n_items, n_fails);
		$display("including oversized, zero-size, unknown and out-of-heap requests.");
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#100000000;
		$display("Mismatches found");
		$finish;
	end
endmodule

[sim.f]
src/flha_pkg.sv
src/flha_hdr_ram.sv
src/free_list_heap_allocator.sv
src/flha_checker.sv
verif/flha_checker.sv
verif/tb_free_list_heap_allocator.sv
